/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rbv_pkg.sv */
// Types and constants of the rigid body velocity step block.
package rbv_pkg;

    localparam logic [2:0] REG_BODY_MASS  = 3'd0;
    localparam logic [2:0] REG_FRICTION   = 3'd1;
    localparam logic [2:0] REG_GRAVITY_X  = 3'd2;
    localparam logic [2:0] REG_GRAVITY_Y  = 3'd3;
    localparam logic [2:0] REG_SIDE_LIMIT = 3'd4;
    localparam logic [2:0] REG_FALL_LIMIT = 3'd5;

    localparam logic [31:0] RST_BODY_MASS  = 32'd65536;
    localparam logic [31:0] RST_FRICTION   = 32'd55705600;
    localparam logic [31:0] RST_GRAVITY_X  = 32'd0;
    localparam logic [31:0] RST_GRAVITY_Y  = 32'd98304000;
    localparam logic [30:0] RST_SIDE_LIMIT = 31'd32768000;
    localparam logic [30:0] RST_FALL_LIMIT = 31'd327680000;

    typedef enum logic {
        DU_DIV,
        DU_SQRT
    } t_du_op;

    typedef struct packed {
        logic        start;
        t_du_op      op;
        logic [63:0] num;
        logic [31:0] den;
    } t_du_req;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] fric;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [30:0] slim;
        logic [30:0] flim;
    } t_cfg;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [15:0] dt;
        logic        gnd;
        logic [31:0] px;
        logic [31:0] py;
    } t_item;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
    } t_res;

    typedef enum logic [5:0] {
        S_IDLE, S_NORM, S_LEN_X, S_LEN_Y, S_LEN_SET, S_U_DIV, S_U_SET,
        S_F_MUL, S_F_ADD, S_GV_MUL, S_GV_ADD, S_D_X, S_D_Y, S_D_SET,
        S_GR_MUL, S_GR_SUB, S_PAR_MUL, S_PAR_SET, S_SL_X, S_SL_Y, S_SL_SET,
        S_FL_MUL, S_FL_SET, S_SC_MUL, S_SC_SET, S_COMB, S_FM_MUL, S_FS_HI,
        S_FS_LO, S_SP_X, S_SP_Y, S_SP_SET, S_FR_MUL, S_FR_SUB, S_PO_MUL,
        S_PO_ADD, S_DONE, S_WAIT
    } t_state;

endpackage

/* rtl/rbv_divsqrt.sv */
// Shared iterative unit: 64/32 unsigned divide and 64-bit integer square root.
module rbv_divsqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbv_pkg::t_du_req i_req,
    output logic           o_done,
    output logic [63:0]    o_res
);
    import rbv_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    t_du_op      r_op, n_op;
    logic [63:0] r_x, n_x;
    logic [63:0] r_r, n_r;
    logic [63:0] r_b, n_b;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;

    logic [32:0] w_rem_sh;
    logic        w_ge;
    logic [63:0] w_t;

    assign w_rem_sh = {r_rem, r_x[63]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_t      = r_r + r_b;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_x    = r_x;
        n_r    = r_r;
        n_b    = r_b;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_x    = i_req.num;
            n_r    = '0;
            n_b    = 64'h4000_0000_0000_0000;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = (i_req.op == DU_DIV) ? 6'd63 : 6'd31;
        end else if (r_busy) begin
            case (r_op)
                DU_DIV: begin
                    n_rem = w_ge ? 32'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[31:0];
                    n_x   = {r_x[62:0], 1'b0};
                    n_r   = {r_r[62:0], w_ge};
                end
                DU_SQRT: begin
                    if (r_x >= w_t) begin
                        n_x = r_x - w_t;
                        n_r = (r_r >> 1) + r_b;
                    end else begin
                        n_r = r_r >> 1;
                    end
                    n_b = r_b >> 2;
                end
                default: n_r = r_r;
            endcase
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= DU_DIV;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_r   <= n_r;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

/* rtl/rbv_seq.sv */
// Step sequencer: datapath registers, shared multiplier and control of the divide/root unit.
module rbv_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbv_pkg::t_cfg     i_cfg,
    input  logic              i_start,
    input  rbv_pkg::t_item    i_item,
    output logic              o_ready,
    input  logic              i_out_free,
    output logic              o_res_done,
    output rbv_pkg::t_res     o_res,
    output rbv_pkg::t_du_req  o_du_req,
    input  logic              i_du_done,
    input  logic [63:0]       i_du_res
);
    import rbv_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sd2147483647)  return 32'sh7FFF_FFFF;
        if (a < -64'sd2147483648) return 32'sh8000_0000;
        return a[31:0];
    endfunction

    function automatic logic signed [63:0] tz30(input logic signed [63:0] a);
        logic signed [63:0] b;
        b = a + (a[63] ? 64'sd1073741823 : 64'sd0);
        return b >>> 30;
    endfunction

    function automatic logic signed [63:0] tz16(input logic signed [63:0] a);
        logic signed [63:0] b;
        b = a + (a[63] ? 64'sd65535 : 64'sd0);
        return b >>> 16;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_axis, n_axis;
    logic   r_pass, n_pass;
    logic   r_neg, n_neg;
    logic   r_gnd, n_gnd;

    logic signed [31:0] r_fx, n_fx, r_fy, n_fy, r_px, n_px, r_py, n_py;
    logic        [15:0] r_dt, n_dt;
    logic signed [31:0] r_vx, n_vx, r_vy, n_vy;
    logic signed [31:0] r_ux, n_ux, r_uy, n_uy;
    logic        [31:0] r_ax, n_ax, r_ay, n_ay;
    logic        [31:0] r_len, n_len, r_slen, n_slen, r_speed, n_speed;
    logic signed [33:0] r_d, n_d;
    logic signed [31:0] r_parx, n_parx, r_pary, n_pary, r_sdx, n_sdx, r_sdy, n_sdy;
    logic        [47:0] r_fm, n_fm, r_step, n_step;
    logic signed [63:0] r_acc, n_acc;
    logic        [63:0] r_q, n_q;
    logic signed [31:0] r_posx, n_posx, r_posy, n_posy;

    logic signed [31:0] w_v, w_u, w_g, w_f, w_p, w_sd, w_par_c, w_sd_c;
    logic        [31:0] w_a, w_mass;
    logic signed [33:0] w_ma, w_mb, w_dmag;
    logic signed [67:0] w_prod;
    logic signed [63:0] w_pr, w_sq, w_tz30, w_tz16, w_vnew;
    logic        [47:0] w_fm_c;
    t_du_req            w_req;

    assign w_v    = r_axis ? r_vy : r_vx;
    assign w_u    = r_axis ? r_uy : r_ux;
    assign w_g    = $signed(r_axis ? i_cfg.gy : i_cfg.gx);
    assign w_f    = r_axis ? r_fy : r_fx;
    assign w_p    = r_axis ? r_py : r_px;
    assign w_sd   = r_axis ? r_sdy : r_sdx;
    assign w_a    = r_axis ? r_ay : r_ax;
    assign w_mass = (i_cfg.mass == 32'd0) ? 32'd1 : i_cfg.mass;

    assign w_prod = w_ma * w_mb;
    assign w_pr   = w_prod[63:0];
    assign w_sq   = r_neg ? -$signed(r_q) : $signed(r_q);
    assign w_tz30 = tz30(r_acc);
    assign w_tz16 = tz16(r_acc);
    assign w_dmag = r_d[33] ? -r_d : r_d;
    assign w_fm_c = (r_acc[63:16] > 48'h8000_0000_0000) ? 48'h8000_0000_0000 : r_acc[63:16];
    assign w_par_c = sat32(w_tz30);
    assign w_sd_c  = sat32(64'(w_v) - 64'(w_par_c));

    // multiplier operands by step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LEN_X:             begin w_ma = {2'b00, r_ax}; w_mb = {2'b00, r_ax}; end
            S_LEN_Y:             begin w_ma = {2'b00, r_ay}; w_mb = {2'b00, r_ay}; end
            S_F_MUL:             begin w_ma = 34'(w_f); w_mb = {18'd0, r_dt}; end
            S_GV_MUL:            begin w_ma = 34'(w_g); w_mb = {18'd0, r_dt}; end
            S_D_X:               begin w_ma = 34'(r_vx); w_mb = 34'(r_ux); end
            S_D_Y:               begin w_ma = 34'(r_vy); w_mb = 34'(r_uy); end
            S_GR_MUL, S_PAR_MUL: begin w_ma = 34'(w_u); w_mb = r_d; end
            S_SL_X:              begin w_ma = 34'(r_sdx); w_mb = 34'(r_sdx); end
            S_SL_Y:              begin w_ma = 34'(r_sdy); w_mb = 34'(r_sdy); end
            S_FL_MUL:            begin w_ma = 34'(w_u); w_mb = {3'b000, i_cfg.flim}; end
            S_SC_MUL:            begin w_ma = 34'(w_sd); w_mb = {3'b000, i_cfg.slim}; end
            S_FM_MUL:            begin w_ma = {2'b00, i_cfg.fric}; w_mb = {2'b00, i_cfg.mass}; end
            S_FS_HI:             begin w_ma = {18'd0, w_fm_c[47:32]}; w_mb = {18'd0, r_dt}; end
            S_FS_LO:             begin w_ma = {2'b00, r_fm[31:0]}; w_mb = {18'd0, r_dt}; end
            S_SP_X:              begin w_ma = 34'(r_vx); w_mb = 34'(r_vx); end
            S_SP_Y:              begin w_ma = 34'(r_vy); w_mb = 34'(r_vy); end
            S_FR_MUL:            begin w_ma = 34'(w_v); w_mb = {2'b00, r_step[31:0]}; end
            S_PO_MUL:            begin w_ma = 34'(w_v); w_mb = {18'd0, r_dt}; end
            default:             begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_axis = r_axis; n_pass = r_pass;
        n_neg = r_neg; n_gnd = r_gnd;
        n_fx = r_fx; n_fy = r_fy; n_px = r_px; n_py = r_py; n_dt = r_dt;
        n_vx = r_vx; n_vy = r_vy; n_ux = r_ux; n_uy = r_uy; n_ax = r_ax; n_ay = r_ay;
        n_len = r_len; n_slen = r_slen; n_speed = r_speed; n_d = r_d;
        n_parx = r_parx; n_pary = r_pary; n_sdx = r_sdx; n_sdy = r_sdy;
        n_fm = r_fm; n_step = r_step; n_acc = r_acc; n_q = r_q;
        n_posx = r_posx; n_posy = r_posy;
        w_req = '{start: 1'b0, op: DU_DIV, num: 64'd0, den: 32'd0};
        o_res_done = 1'b0;
        w_vnew = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_fx = i_item.fx; n_fy = i_item.fy; n_dt = i_item.dt;
                    n_gnd = i_item.gnd; n_px = i_item.px; n_py = i_item.py;
                    n_ax = i_cfg.gx[31] ? (~i_cfg.gx + 32'd1) : i_cfg.gx;
                    n_ay = i_cfg.gy[31] ? (~i_cfg.gy + 32'd1) : i_cfg.gy;
                    n_axis = 1'b0;
                    if (i_cfg.gx == 32'd0 && i_cfg.gy == 32'd0) begin
                        // no gravity: unit vector stays zero
                        n_ux = '0; n_uy = '0;
                        n_state = S_F_MUL;
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_ax < 32'h4000_0000 && r_ay < 32'h4000_0000) begin
                    n_ax = r_ax << 1;
                    n_ay = r_ay << 1;
                end else begin
                    n_state = S_LEN_X;
                end
            end
            S_LEN_X: begin
                n_acc = w_pr;
                n_state = S_LEN_Y;
            end
            S_LEN_Y: begin
                w_req = '{start: 1'b1, op: DU_SQRT, num: 64'(r_acc + w_pr), den: 32'd0};
                n_ret = S_LEN_SET; n_state = S_WAIT;
            end
            S_LEN_SET: begin
                n_len = r_q[31:0];
                n_axis = 1'b0;
                n_state = S_U_DIV;
            end
            S_U_DIV: begin
                w_req = '{start: 1'b1, op: DU_DIV, num: {2'b00, w_a, 30'd0}, den: r_len};
                n_ret = S_U_SET; n_state = S_WAIT;
            end
            S_U_SET: begin
                if (!r_axis) begin
                    n_ux = w_g[31] ? -$signed(r_q[31:0]) : $signed(r_q[31:0]);
                    n_axis = 1'b1; n_state = S_U_DIV;
                end else begin
                    n_uy = w_g[31] ? -$signed(r_q[31:0]) : $signed(r_q[31:0]);
                    n_axis = 1'b0; n_state = S_F_MUL;
                end
            end
            S_F_MUL: begin
                n_neg = w_pr[63];
                w_req = '{start: 1'b1, op: DU_DIV, num: mag64(w_pr), den: w_mass};
                n_ret = S_F_ADD; n_state = S_WAIT;
            end
            S_F_ADD: begin
                w_vnew = 64'(w_v) + w_sq;
                if (!r_axis) begin
                    n_vx = sat32(w_vnew); n_axis = 1'b1; n_state = S_F_MUL;
                end else begin
                    n_vy = sat32(w_vnew); n_axis = 1'b0;
                    n_pass = 1'b0;
                    n_state = r_gnd ? S_D_X : S_GV_MUL;
                end
            end
            S_GV_MUL: begin
                n_acc = w_pr; n_state = S_GV_ADD;
            end
            S_GV_ADD: begin
                w_vnew = 64'(w_v) + w_tz16;
                if (!r_axis) begin
                    n_vx = sat32(w_vnew); n_axis = 1'b1; n_state = S_GV_MUL;
                end else begin
                    n_vy = sat32(w_vnew); n_axis = 1'b0;
                    n_pass = 1'b1; n_state = S_D_X;
                end
            end
            S_D_X: begin
                n_acc = w_pr; n_state = S_D_Y;
            end
            S_D_Y: begin
                n_acc = r_acc + w_pr; n_state = S_D_SET;
            end
            S_D_SET: begin
                // along-gravity speed
                n_d = w_tz30[33:0];
                n_axis = 1'b0;
                n_state = r_pass ? S_PAR_MUL : S_GR_MUL;
            end
            S_GR_MUL: begin
                n_acc = w_pr; n_state = S_GR_SUB;
            end
            S_GR_SUB: begin
                w_vnew = 64'(w_v) - w_tz30;
                if (!r_axis) begin
                    n_vx = sat32(w_vnew); n_axis = 1'b1; n_state = S_GR_MUL;
                end else begin
                    n_vy = sat32(w_vnew); n_axis = 1'b0;
                    n_pass = 1'b1; n_state = S_D_X;
                end
            end
            S_PAR_MUL: begin
                n_acc = w_pr; n_state = S_PAR_SET;
            end
            S_PAR_SET: begin
                if (!r_axis) begin
                    n_parx = w_par_c; n_sdx = w_sd_c;
                    n_axis = 1'b1; n_state = S_PAR_MUL;
                end else begin
                    n_pary = w_par_c; n_sdy = w_sd_c;
                    n_axis = 1'b0; n_state = S_SL_X;
                end
            end
            S_SL_X: begin
                n_acc = w_pr; n_state = S_SL_Y;
            end
            S_SL_Y: begin
                w_req = '{start: 1'b1, op: DU_SQRT, num: 64'(r_acc + w_pr), den: 32'd0};
                n_ret = S_SL_SET; n_state = S_WAIT;
            end
            S_SL_SET: begin
                n_slen = r_q[31:0];
                n_axis = 1'b0;
                if (w_dmag > {3'b000, i_cfg.flim}) begin
                    n_state = S_FL_MUL;
                end else if (r_q[31:0] > {1'b0, i_cfg.slim}) begin
                    n_state = S_SC_MUL;
                end else begin
                    n_state = S_COMB;
                end
            end
            S_FL_MUL: begin
                n_acc = w_pr; n_state = S_FL_SET;
            end
            S_FL_SET: begin
                w_vnew = r_d[33] ? -w_tz30 : w_tz30;
                if (!r_axis) begin
                    n_parx = w_vnew[31:0]; n_axis = 1'b1; n_state = S_FL_MUL;
                end else begin
                    n_pary = w_vnew[31:0]; n_axis = 1'b0;
                    n_state = (r_slen > {1'b0, i_cfg.slim}) ? S_SC_MUL : S_COMB;
                end
            end
            S_SC_MUL: begin
                n_neg = w_pr[63];
                w_req = '{start: 1'b1, op: DU_DIV, num: mag64(w_pr), den: r_slen};
                n_ret = S_SC_SET; n_state = S_WAIT;
            end
            S_SC_SET: begin
                if (!r_axis) begin
                    n_sdx = w_sq[31:0]; n_axis = 1'b1; n_state = S_SC_MUL;
                end else begin
                    n_sdy = w_sq[31:0]; n_axis = 1'b0; n_state = S_COMB;
                end
            end
            S_COMB: begin
                n_vx = sat32(64'(r_parx) + 64'(r_sdx));
                n_vy = sat32(64'(r_pary) + 64'(r_sdy));
                n_state = S_FM_MUL;
            end
            S_FM_MUL: begin
                n_axis = 1'b0;
                if (r_vx == 32'sd0 && r_vy == 32'sd0) begin
                    n_state = S_PO_MUL;
                end else begin
                    n_acc = w_pr; n_state = S_FS_HI;
                end
            end
            S_FS_HI: begin
                n_fm = w_fm_c;
                n_acc = w_pr; n_state = S_FS_LO;
            end
            S_FS_LO: begin
                n_acc = (r_acc <<< 32) + w_pr; n_state = S_SP_X;
            end
            S_SP_X: begin
                n_step = r_acc[63:16];
                n_acc = w_pr; n_state = S_SP_Y;
            end
            S_SP_Y: begin
                w_req = '{start: 1'b1, op: DU_SQRT, num: 64'(r_acc + w_pr), den: 32'd0};
                n_ret = S_SP_SET; n_state = S_WAIT;
            end
            S_SP_SET: begin
                n_speed = r_q[31:0];
                n_axis = 1'b0;
                if ({16'd0, r_q[31:0]} < r_step) begin
                    // friction stops the body
                    n_vx = '0; n_vy = '0;
                    n_state = S_PO_MUL;
                end else begin
                    n_state = S_FR_MUL;
                end
            end
            S_FR_MUL: begin
                n_neg = w_pr[63];
                w_req = '{start: 1'b1, op: DU_DIV, num: mag64(w_pr), den: r_speed};
                n_ret = S_FR_SUB; n_state = S_WAIT;
            end
            S_FR_SUB: begin
                w_vnew = 64'(w_v) - w_sq;
                if (!r_axis) begin
                    n_vx = sat32(w_vnew); n_axis = 1'b1; n_state = S_FR_MUL;
                end else begin
                    n_vy = sat32(w_vnew); n_axis = 1'b0; n_state = S_PO_MUL;
                end
            end
            S_PO_MUL: begin
                n_acc = w_pr; n_state = S_PO_ADD;
            end
            S_PO_ADD: begin
                w_vnew = 64'(w_p) + w_tz16;
                if (!r_axis) begin
                    n_posx = sat32(w_vnew); n_axis = 1'b1; n_state = S_PO_MUL;
                end else begin
                    n_posy = sat32(w_vnew); n_axis = 1'b0; n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (i_du_done) begin
                    n_q = i_du_res;
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_axis  <= 1'b0;
            r_pass  <= 1'b0;
            r_vx    <= '0;
            r_vy    <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_axis  <= n_axis;
            r_pass  <= n_pass;
            r_vx    <= n_vx;
            r_vy    <= n_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg; r_gnd <= n_gnd;
        r_fx <= n_fx; r_fy <= n_fy; r_px <= n_px; r_py <= n_py; r_dt <= n_dt;
        r_ux <= n_ux; r_uy <= n_uy; r_ax <= n_ax; r_ay <= n_ay;
        r_len <= n_len; r_slen <= n_slen; r_speed <= n_speed; r_d <= n_d;
        r_parx <= n_parx; r_pary <= n_pary; r_sdx <= n_sdx; r_sdy <= n_sdy;
        r_fm <= n_fm; r_step <= n_step; r_acc <= n_acc; r_q <= n_q;
        r_posx <= n_posx; r_posy <= n_posy;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_du_req = w_req;
    assign o_res    = '{pos_x: r_posx, pos_y: r_posy, vel_x: r_vx, vel_y: r_vy};

endmodule

/* rtl/rigid_body_velocity_step_top.sv */
// Top level: config registers, item handshake, output register, sequencer and divide/root unit.
//
//  channel  | valid        | stall        | payload
//  in       | i_in_valid   | o_in_stall   | i_force_x/y, i_time_step, i_grounded, i_pos_in_x/y
//  out      | o_out_valid  | i_out_stall  | o_pos_out_x/y, o_vel_out_x/y
//  cfg      | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// An item runs its divisions and square roots one after another on the shared divide/root
// unit; when gravity is set, a normalization pass of shift steps comes first.
// Reset is synchronous; no clearing pass, the block is ready the cycle after reset.
// A finished result sits in the output register; the next item is taken meanwhile and
// holds in its last step until that register frees.
module rigid_body_velocity_step_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_force_x,
    input  logic [31:0] i_force_y,
    input  logic [15:0] i_time_step,
    input  logic        i_grounded,
    input  logic [31:0] i_pos_in_x,
    input  logic [31:0] i_pos_in_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pos_out_x,
    output logic [31:0] o_pos_out_y,
    output logic [31:0] o_vel_out_x,
    output logic [31:0] o_vel_out_y
);
    import rbv_pkg::*;
    `include "assert_macros.svh"

    t_cfg    r_cfg, n_cfg;
    logic    r_out_valid, n_out_valid;
    t_res    r_out, n_out;
    t_item   w_item;
    t_res    w_res;
    t_du_req w_du_req;
    logic    w_ready, w_start, w_out_free, w_res_done, w_du_done;
    logic [63:0] w_du_res;

    assign w_item = '{fx: i_force_x, fy: i_force_y, dt: i_time_step, gnd: i_grounded,
                      px: i_pos_in_x, py: i_pos_in_y};
    assign w_start    = i_in_valid && w_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BODY_MASS:  n_cfg.mass = i_cfg_data;
                REG_FRICTION:   n_cfg.fric = i_cfg_data;
                REG_GRAVITY_X:  n_cfg.gx   = i_cfg_data;
                REG_GRAVITY_Y:  n_cfg.gy   = i_cfg_data;
                REG_SIDE_LIMIT: n_cfg.slim = i_cfg_data[30:0];
                REG_FALL_LIMIT: n_cfg.flim = i_cfg_data[30:0];
                default:        n_cfg = r_cfg;
            endcase
        end
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_res_done) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mass: RST_BODY_MASS, fric: RST_FRICTION, gx: RST_GRAVITY_X,
                       gy: RST_GRAVITY_Y, slim: RST_SIDE_LIMIT, flim: RST_FALL_LIMIT};
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    rbv_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (w_start),
        .i_item     (w_item),
        .o_ready    (w_ready),
        .i_out_free (w_out_free),
        .o_res_done (w_res_done),
        .o_res      (w_res),
        .o_du_req   (w_du_req),
        .i_du_done  (w_du_done),
        .i_du_res   (w_du_res)
    );

    rbv_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_du_req),
        .o_done  (w_du_done),
        .o_res   (w_du_res)
    );

    assign o_in_stall  = !w_ready;
    assign o_out_valid = r_out_valid;
    assign o_pos_out_x = r_out.pos_x;
    assign o_pos_out_y = r_out.pos_y;
    assign o_vel_out_x = r_out.vel_x;
    assign o_vel_out_y = r_out.vel_y;

    // an accepted item keeps the sequencer busy
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_start, o_in_stall)
    // a finished result always lands in the output register
    `ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_res_done, r_out_valid)
    // the output register fills only from a finished item
    `ASSERT_SAME(a_out_source, i_clk, i_rst_n, $rose(r_out_valid), $past(w_res_done))
    // divide/root unit is never started while a result waits on it
    `ASSERT_SAME(a_no_restart, i_clk, i_rst_n, w_du_req.start, !w_du_done)

endmodule
